@@ rtl/core/pdlt_pkg.sv @@
`default_nettype none

package pdlt_pkg;

  // Store size and reporting limit
  localparam int LINE_DEPTH = 256;
  localparam int TOKEN_CAP  = 16;

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int WPW = $clog2(LINE_DEPTH + 1);
  localparam int CW  = $clog2(TOKEN_CAP + 1);

  // Configuration port
  localparam int PAW = 3;
  localparam logic [PAW-3:0] REG_TOKEN_LIMIT = '0;
  localparam logic [4:0] TOKEN_LIMIT_RST = 5'd16;

  // Request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_EOL    = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TOKEN   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Character codes
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_BKSP     = 8'h08;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_CASE_GAP = 8'h20;
  localparam logic [7:0] DIGIT_TEN   = 8'd10;

  typedef enum logic [1:0] {
    PM_NONE,
    PM_PCT,
    PM_DIG,
    PM_ESC
  } pend_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_SCAN,
    ST_SUM,
    ST_READ
  } st_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_in;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] token_start;
    logic [8:0] token_length;
    logic [4:0] token_total;
    logic       line_overflow;
    logic [7:0] byte_out;
    logic       last;
  } out_t;

  // One store update: write strobe, address, byte, new fill level, drop flag
  typedef struct packed {
    logic           we;
    logic [AW-1:0]  addr;
    logic [7:0]     data;
    logic [WPW-1:0] wp;
    logic           ovf;
  } wr_t;

  function automatic logic [7:0] digit_val(input logic [7:0] c);
    logic [7:0] u;
    begin
      u = c;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) u = c - CH_CASE_GAP;
      digit_val = (c <= CH_NINE) ? c - CH_ZERO : u - CH_UPPER_A + DIGIT_TEN;
    end
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] hi_c,
                                             input logic [7:0] lo_c);
    logic [7:0] hi;
    begin
      hi = digit_val(hi_c);
      decode_pair = {hi[3:0], 4'b0000} + digit_val(lo_c);
    end
  endfunction

  function automatic wr_t put_step(input logic [WPW-1:0] wp, input logic [7:0] b);
    wr_t r;
    begin
      r.we   = (32'(wp) < LINE_DEPTH);
      r.addr = AW'(wp);
      r.data = b;
      r.wp   = r.we ? wp + WPW'(1) : wp;
      r.ovf  = !r.we;
      put_step = r;
    end
  endfunction

  function automatic wr_t plain_step(input logic [WPW-1:0] wp, input logic [7:0] c);
    wr_t r;
    begin
      if (c == CH_BKSP) begin
        r.we   = 1'b0;
        r.addr = AW'(wp);
        r.data = '0;
        r.wp   = (wp != '0) ? wp - WPW'(1) : wp;
        r.ovf  = 1'b0;
      end else if (c <= CH_SPACE) begin
        r = put_step(wp, 8'h00);
      end else begin
        r = put_step(wp, c);
      end
      plain_step = r;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pdlt_ram.sv @@
`default_nettype none

module pdlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/pdlt_apb.sv @@
`default_nettype none

module pdlt_apb
  import pdlt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output logic [CW-1:0]  limit_eff
);

  logic [4:0] token_limit_r;
  logic       wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready &&
                  (paddr[PAW-1:2] == REG_TOKEN_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_limit_r <= TOKEN_LIMIT_RST;
    end else if (wr_hit) begin
      token_limit_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[PAW-1:2] == REG_TOKEN_LIMIT) ? {27'b0, token_limit_r} : '0;

  // Clamp zero up to one and anything past the token capacity down to it
  always_comb begin
    if (token_limit_r == 5'd0) begin
      limit_eff = CW'(1);
    end else if (32'(token_limit_r) > TOKEN_CAP) begin
      limit_eff = CW'(TOKEN_CAP);
    end else begin
      limit_eff = CW'(token_limit_r);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/percent_decode_line_tokenizer.sv @@
`default_nettype none

// Line tokenizer with percent decoding.
// Command channel: an item transfers on a rising edge with start high and busy
// low. req_type append cleans one character into the line store (percent pairs
// decode to one byte, backslash escapes, backspace drops the last byte, control
// characters and space become separator zeros). busy stays low on an append, so
// appends can stream at one per cycle.
// Read: the store output is registered, then the read state registers the byte
// onto the result port; busy is high in the read state.
// End of line: a waiting percent or backslash is stored as a literal in the
// transfer cycle; a waiting first digit follows in a flush state. Then the
// store is walked with one memory read per cycle, descriptors come out as runs
// close and the summary last. busy stays high through the flush, walk and
// summary states, and the walk ends early when the token limit is reached; the
// summary shows in the first cycle with busy low.
// Results hold the port for exactly one cycle with out_valid; the receiver
// cannot stall them. Each result is a transfer with no back-pressure.
// Reset clears the fill level, pending escape state and flags; the token limit
// returns to 16. Store contents are undefined until written, so no clearing
// pass runs after reset.
module percent_decode_line_tokenizer
  import pdlt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  in_t            in_item,
  output logic           out_valid,
  output out_t           out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [PAW-1:0] paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  st_t            st_r, st_nxt;
  logic [WPW-1:0] wp_r, wp_nxt;
  pend_t          mode_r, mode_nxt;
  logic [7:0]     first_r, first_nxt;
  logic           ovf_r, ovf_nxt;
  logic           closed_r, closed_nxt;

  // scan walker
  logic [WPW-1:0] ra_r, ra_nxt;
  logic           rv_r, rv_nxt;
  logic [AW-1:0]  ri_r, ri_nxt;
  logic           in_tok_r, in_tok_nxt;
  logic [AW-1:0]  tstart_r, tstart_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           oob_r, oob_nxt;

  out_t           out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [CW-1:0]  limit_eff;
  logic           accept;
  wr_t            step;
  logic           step_en;
  logic [WPW-1:0] wp_e;
  logic           ovf_e;
  pend_t          mode_e;
  logic           tok_done;
  logic [WPW-1:0] tok_len;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  pdlt_apb u_apb (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .limit_eff (limit_eff)
  );

  pdlt_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign busy      = (st_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A closed line restarts on the first append
  assign wp_e   = closed_r ? '0 : wp_r;
  assign ovf_e  = closed_r ? 1'b0 : ovf_r;
  assign mode_e = closed_r ? PM_NONE : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      mode_r      <= PM_NONE;
      first_r     <= '0;
      ovf_r       <= 1'b0;
      closed_r    <= 1'b0;
      rv_r        <= 1'b0;
      in_tok_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      mode_r      <= mode_nxt;
      first_r     <= first_nxt;
      ovf_r       <= ovf_nxt;
      closed_r    <= closed_nxt;
      rv_r        <= rv_nxt;
      in_tok_r    <= in_tok_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walker position need no reset
  always_ff @(posedge clk) begin
    ra_r     <= ra_nxt;
    ri_r     <= ri_nxt;
    tstart_r <= tstart_nxt;
    oob_r    <= oob_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    wp_nxt        = wp_r;
    mode_nxt      = mode_r;
    first_nxt     = first_r;
    ovf_nxt       = ovf_r;
    closed_nxt    = closed_r;
    ra_nxt        = ra_r;
    rv_nxt        = rv_r;
    ri_nxt        = ri_r;
    in_tok_nxt    = in_tok_r;
    tstart_nxt    = tstart_r;
    count_nxt     = count_r;
    oob_nxt       = oob_r;
    out_nxt       = '0;
    out_valid_nxt = 1'b0;
    step          = plain_step(wp_r, first_r);
    step_en       = 1'b0;
    tok_done      = 1'b0;
    tok_len       = '0;
    ram_raddr     = AW'(in_item.read_index);

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.req_type)
            REQ_APPEND: begin
              closed_nxt = 1'b0;
              wp_nxt     = wp_e;
              ovf_nxt    = ovf_e;
              case (mode_e)
                PM_PCT: begin
                  first_nxt = in_item.char_in;
                  mode_nxt  = PM_DIG;
                end
                PM_DIG: begin
                  step     = put_step(wp_e, decode_pair(first_r, in_item.char_in));
                  step_en  = 1'b1;
                  mode_nxt = PM_NONE;
                end
                PM_ESC: begin
                  step     = put_step(wp_e, in_item.char_in);
                  step_en  = 1'b1;
                  mode_nxt = PM_NONE;
                end
                default: begin
                  mode_nxt = PM_NONE;
                  if (in_item.char_in == CH_PERCENT) begin
                    mode_nxt = PM_PCT;
                  end else if (in_item.char_in == CH_BSLASH) begin
                    mode_nxt = PM_ESC;
                  end else begin
                    step    = plain_step(wp_e, in_item.char_in);
                    step_en = 1'b1;
                  end
                end
              endcase
            end
            REQ_EOL: begin
              // Flush the waiting escape lead as a literal; a waiting
              // first digit is stored in the flush state
              step       = plain_step(wp_r, (mode_r == PM_ESC) ? CH_BSLASH : CH_PERCENT);
              step_en    = (mode_r != PM_NONE);
              mode_nxt   = PM_NONE;
              closed_nxt = 1'b1;
              ra_nxt     = '0;
              rv_nxt     = 1'b0;
              in_tok_nxt = 1'b0;
              count_nxt  = '0;
              st_nxt     = (mode_r == PM_DIG) ? ST_FLUSH : ST_SCAN;
            end
            REQ_READ: begin
              oob_nxt = !(32'(in_item.read_index) < LINE_DEPTH);
              st_nxt  = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end

      ST_FLUSH: begin
        step    = plain_step(wp_r, first_r);
        step_en = 1'b1;
        st_nxt  = ST_SCAN;
      end

      ST_SCAN: begin
        // Evaluate the byte read last cycle
        if (rv_r) begin
          if (ram_rdata != 8'h00) begin
            if (!in_tok_r) begin
              in_tok_nxt = 1'b1;
              tstart_nxt = ri_r;
            end
          end else if (in_tok_r) begin
            tok_done   = 1'b1;
            tok_len    = WPW'(ri_r) - WPW'(tstart_r);
            in_tok_nxt = 1'b0;
          end
        end else if (ra_r >= wp_r) begin
          if (in_tok_r) begin
            tok_done   = 1'b1;
            tok_len    = wp_r - WPW'(tstart_r);
            in_tok_nxt = 1'b0;
          end
          st_nxt = ST_SUM;
        end
        // Issue the next read
        if (ra_r < wp_r) begin
          ram_raddr = AW'(ra_r);
          ri_nxt    = AW'(ra_r);
          rv_nxt    = 1'b1;
          ra_nxt    = ra_r + WPW'(1);
        end else begin
          rv_nxt = 1'b0;
        end
        if (tok_done) begin
          out_valid_nxt        = 1'b1;
          out_nxt.result_kind  = KIND_TOKEN;
          out_nxt.token_start  = 8'(tstart_r);
          out_nxt.token_length = 9'(tok_len);
          count_nxt            = count_r + CW'(1);
          if (count_nxt == limit_eff) begin
            st_nxt = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        out_valid_nxt         = 1'b1;
        out_nxt.result_kind   = KIND_SUMMARY;
        out_nxt.token_total   = 5'(count_r);
        out_nxt.line_overflow = ovf_r;
        out_nxt.last          = 1'b1;
        st_nxt                = ST_IDLE;
      end

      ST_READ: begin
        out_valid_nxt       = 1'b1;
        out_nxt.result_kind = KIND_READ;
        out_nxt.byte_out    = oob_r ? 8'h00 : ram_rdata;
        out_nxt.last        = 1'b1;
        st_nxt              = ST_IDLE;
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (step_en) begin
      wp_nxt  = step.wp;
      ovf_nxt = ovf_nxt | step.ovf;
    end
  end

  assign ram_we    = step_en && step.we;
  assign ram_waddr = step.addr;
  assign ram_wdata = step.data;

  // Fill level never passes the store size
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) <= LINE_DEPTH)
    else $error("write position beyond store depth");

  // The walk never reports more tokens than the limit
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (count_r < limit_eff))
    else $error("token count reached limit inside scan");

  // A read is answered with a read result marked last
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.req_type == REQ_READ) |=> ##1
      (out_valid && out_item.result_kind == KIND_READ && out_item.last))
    else $error("read result missing");

  // Nothing is written to the store while it is being walked
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> !ram_we)
    else $error("store written during scan");

endmodule

`default_nettype wire

@@ bench/percent_decode_line_tokenizer_tb.sv @@
module percent_decode_line_tokenizer_tb;
  import pdlt_pkg::*;

  // The package has no name for the fourth request code; the block ignores it.
  localparam logic [1:0] REQ_NOP = 2'd3;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  in_t            in_item = '0;
  logic           out_valid;
  out_t           out_item;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  percent_decode_line_tokenizer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: line store, fill level, escape state, flags and the
  // token limit register. Updated once per accepted command transfer.
  // ---------------------------------------------------------------------------
  logic [7:0]  line_mem [LINE_DEPTH];
  int unsigned fill_pos = 0;
  int unsigned high_water = 0;   // store entries below this were written
  pend_t       esc_state = PM_NONE;
  logic [7:0]  esc_first = '0;
  bit          drop_seen = 1'b0;
  bit          line_done = 1'b0;
  logic [4:0]  limit_reg = TOKEN_LIMIT_RST;

  out_t        report_q [$];     // results still owed by the block, oldest first
  in_t         item_q [$];       // commands waiting for the driver
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned gap_left = 0;
  bit          burst_mode = 1'b0;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
  end

  function automatic void store_byte(logic [7:0] b);
    if (fill_pos < LINE_DEPTH) begin
      line_mem[fill_pos] = b;
      fill_pos++;
      if (fill_pos > high_water) high_water = fill_pos;
    end else begin
      drop_seen = 1'b1;
    end
  endfunction

  // Plain rules: backspace pulls the fill level back, control and space
  // characters become separator zeros, everything else is stored as is.
  function automatic void clean_char(logic [7:0] c);
    if (c == CH_BKSP) begin
      if (fill_pos != 0) fill_pos--;
    end else if (c <= CH_SPACE) begin
      store_byte(8'h00);
    end else begin
      store_byte(c);
    end
  endfunction

  // Hex digit value with no validity check; wraps modulo 256.
  function automatic logic [7:0] nibble_of(logic [7:0] c);
    logic [7:0] u;
    if (c <= CH_NINE) return c - CH_ZERO;
    u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CH_CASE_GAP : c;
    return u - CH_UPPER_A + DIGIT_TEN;
  endfunction

  function automatic void clean_and_scan(in_t it);
    out_t        r;
    logic [7:0]  hi;
    int unsigned lim, cnt, p, s;
    case (it.req_type)
      REQ_APPEND: begin
        // First append after an end of line opens a fresh line.
        if (line_done) begin
          fill_pos  = 0;
          drop_seen = 1'b0;
          esc_state = PM_NONE;
          line_done = 1'b0;
        end
        case (esc_state)
          PM_PCT: begin
            esc_first = it.char_in;
            esc_state = PM_DIG;
          end
          PM_DIG: begin
            hi = nibble_of(esc_first);
            store_byte({hi[3:0], 4'b0000} + nibble_of(it.char_in));
            esc_state = PM_NONE;
          end
          PM_ESC: begin
            store_byte(it.char_in);
            esc_state = PM_NONE;
          end
          default: begin
            if (it.char_in == CH_PERCENT) esc_state = PM_PCT;
            else if (it.char_in == CH_BSLASH) esc_state = PM_ESC;
            else clean_char(it.char_in);
          end
        endcase
      end
      REQ_EOL: begin
        // Replay whatever is still waiting under the plain rules.
        case (esc_state)
          PM_PCT: clean_char(CH_PERCENT);
          PM_DIG: begin
            clean_char(CH_PERCENT);
            clean_char(esc_first);
          end
          PM_ESC: clean_char(CH_BSLASH);
          default: ;
        endcase
        esc_state = PM_NONE;
        line_done = 1'b1;
        lim = limit_reg;
        if (lim == 0) lim = 1;
        if (lim > TOKEN_CAP) lim = TOKEN_CAP;
        cnt = 0;
        p   = 0;
        while (p < fill_pos && cnt < lim) begin
          if (line_mem[p] == 8'h00) begin
            p++;
          end else begin
            s = p;
            while (p < fill_pos && line_mem[p] != 8'h00) p++;
            r = '0;
            r.result_kind  = KIND_TOKEN;
            r.token_start  = 8'(s);
            r.token_length = 9'(p - s);
            report_q.push_back(r);
            cnt++;
          end
        end
        r = '0;
        r.result_kind   = KIND_SUMMARY;
        r.token_total   = 5'(cnt);
        r.line_overflow = drop_seen;
        r.last          = 1'b1;
        report_q.push_back(r);
      end
      REQ_READ: begin
        r = '0;
        r.result_kind = KIND_READ;
        r.byte_out    = line_mem[it.read_index];
        r.last        = 1'b1;
        report_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed commands from item_q. A command transfers on the edge where
  // start is high and busy is low; predict it right there, then either idle
  // for the chosen gap or present the next command without dropping start.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_item  <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        clean_and_scan(in_item);
        n_accepted++;
      end
      // Hold the current command while busy; otherwise advance.
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (item_q.size() != 0) begin
          in_item  <= item_q.pop_front();
          start    <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every out_valid cycle is one result transfer; match it against
  // the oldest owed result.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, out_t want, out_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t %s: expected kind=%0d start=%0d len=%0d total=%0d ovf=%0b byte=%02h last=%0b",
               $realtime, what, want.result_kind, want.token_start, want.token_length,
               want.token_total, want.line_overflow, want.byte_out, want.last);
      $display("%0t %s: actual   kind=%0d start=%0d len=%0d total=%0d ovf=%0b byte=%02h last=%0b",
               $realtime, what, got.result_kind, got.token_start, got.token_length,
               got.token_total, got.line_overflow, got.byte_out, got.last);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (report_q.size() == 0) begin
        note_mismatch("unexpected result", '0, out_item);
      end else begin
        want = report_q.pop_front();
        if (out_item.result_kind   !== want.result_kind   ||
            out_item.token_start   !== want.token_start   ||
            out_item.token_length  !== want.token_length  ||
            out_item.token_total   !== want.token_total   ||
            out_item.line_overflow !== want.line_overflow ||
            out_item.byte_out      !== want.byte_out      ||
            out_item.last          !== want.last)
          note_mismatch("result mismatch", want, out_item);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] rt, logic [7:0] c, logic [7:0] ri);
    in_t it;
    it.req_type   = rt;
    it.char_in    = c;
    it.read_index = ri;
    item_q.push_back(it);
    n_queued++;
  endtask

  task automatic add_char(logic [7:0] c);
    queue_item(REQ_APPEND, c, 8'($urandom));
  endtask

  // Only read entries that have been written at least once.
  task automatic queue_read();
    if (high_water != 0)
      queue_item(REQ_READ, 8'($urandom), 8'($urandom_range(0, high_water - 1)));
  endtask

  // Wait until the driver has handed every queued command to the block.
  task automatic wait_accepted();
    while (n_accepted != n_queued) @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned i;
    i = $urandom_range(0, 21);
    if (i < 10) return CH_ZERO + 8'(i);
    if (i < 16) return CH_LOWER_A + 8'(i - 10);
    return CH_UPPER_A + 8'(i - 16);
  endfunction

  // Token characters: letters, digits and high bytes, never an escape lead-in.
  function automatic logic [7:0] word_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return CH_LOWER_A + 8'($urandom_range(0, 25));
    if (r < 6) return CH_UPPER_A + 8'($urandom_range(0, 25));
    if (r < 8) return CH_ZERO + 8'($urandom_range(0, 9));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return 8'h09;
      2:       return 8'h00;
      default: return 8'($urandom_range(1, 31));
    endcase
  endfunction

  // Close a line: sync so the written range is known, read a few bytes
  // (possibly while an escape is still waiting), end the line, maybe repeat
  // the end of line, then read again.
  task automatic close_line();
    wait_accepted();
    repeat ($urandom_range(0, 2)) queue_read();
    queue_item(REQ_EOL, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 4) == 0) queue_item(REQ_EOL, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(0, 2)) queue_read();
  endtask

  // Mostly well-formed content: words, separators, percent pairs, escapes,
  // backspaces; some raw noise and ignored commands mixed in.
  task automatic random_line();
    int unsigned len, n, k, r;
    r   = $urandom_range(0, 99);
    len = (r < 80) ? $urandom_range(1, 10) : (r < 95) ? $urandom_range(11, 30)
                                                        : $urandom_range(31, 60);
    n = 0;
    while (n < len) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        k = $urandom_range(1, 6);
        repeat (k) add_char(word_char());
        n += k;
      end else if (r < 48) begin
        add_char(sep_char());
        n++;
      end else if (r < 60) begin
        add_char(CH_PERCENT);
        add_char(hex_char());
        add_char(hex_char());
        n += 3;
      end else if (r < 66) begin
        add_char(CH_PERCENT);
        add_char(8'($urandom));
        add_char(8'($urandom));
        n += 3;
      end else if (r < 73) begin
        add_char(CH_BSLASH);
        add_char(8'($urandom));
        n += 2;
      end else if (r < 80) begin
        k = $urandom_range(1, 3);
        repeat (k) add_char(CH_BKSP);
        n += k;
      end else if (r < 92) begin
        add_char(8'($urandom));
        n++;
      end else if (r < 96) begin
        queue_item(REQ_NOP, 8'($urandom), 8'($urandom));
      end else begin
        add_char(CH_PERCENT);
        n++;
      end
    end
    // Leave an escape dangling at the end of some lines.
    r = $urandom_range(0, 99);
    if (r < 10) begin
      add_char(CH_PERCENT);
    end else if (r < 22) begin
      add_char(CH_PERCENT);
      case ($urandom_range(0, 3))
        0:       add_char(CH_BKSP);
        1:       add_char(sep_char());
        2:       add_char(word_char());
        default: add_char(8'($urandom));
      endcase
    end else if (r < 30) begin
      add_char(CH_BSLASH);
    end
    close_line();
  endtask

  // Overrun the store: one unbroken token, or many short words.
  task automatic long_line(bit with_words);
    int unsigned len, n, k;
    len = LINE_DEPTH + $urandom_range(2, 6);
    n   = 0;
    while (n < len) begin
      if (with_words) begin
        k = $urandom_range(1, 5);
        repeat (k) add_char(word_char());
        add_char(CH_SPACE);
        n += k + 1;
      end else begin
        add_char(word_char());
        n++;
      end
    end
    // Step back from a full store, then fill the freed slot again.
    add_char(CH_BKSP);
    add_char(word_char());
    close_line();
  endtask

  // Register write over the configuration port, then read it back. Only
  // called with the block idle and nothing owed.
  task automatic set_token_limit(logic [4:0] v);
    logic [31:0] rd;
    while (n_accepted != n_queued || report_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TOKEN_LIMIT, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit_reg = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(v)) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t token_limit readback: expected %0d actual %0d", $realtime, v, rd);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [4:0] lim_plan [8];
    lim_plan = '{5'd1, 5'd0, 5'd16, 5'd3, 5'($urandom_range(1, 31)), 5'd31, 5'd2,
                 5'($urandom_range(0, 31))};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, token limit at its reset value.
    // End of line on an empty store: summary only.
    queue_item(REQ_EOL, 8'($urandom), 8'($urandom));
    add_char(CH_BKSP);              // backspace with nothing stored
    add_char(CH_UPPER_A);
    add_char(CH_PERCENT);           // %41, plain digits
    add_char(CH_ZERO + 8'd4);
    add_char(CH_ZERO + 8'd1);
    add_char(CH_PERCENT);           // %fF, mixed-case hex
    add_char(CH_LOWER_A + 8'd5);
    add_char(CH_UPPER_A + 8'd5);
    add_char(CH_SPACE);
    add_char(CH_BSLASH);            // escaped percent stored literally
    add_char(CH_PERCENT);
    add_char(8'h00);                // zero character acts as a separator
    add_char(CH_LOWER_A + 8'd23);
    add_char(CH_BKSP);              // drop the last stored byte
    add_char(CH_PERCENT);           // %zZ, no hex check
    add_char(CH_LOWER_Z);
    add_char(CH_UPPER_A + 8'd25);
    add_char(8'hFF);
    queue_item(REQ_EOL, 8'($urandom), 8'($urandom));
    queue_item(REQ_EOL, 8'($urandom), 8'($urandom));   // same line reported again
    queue_item(REQ_READ, 8'($urandom), 8'd1);
    // Percent plus a waiting backspace at end of line.
    add_char(CH_LOWER_A + 8'd1);
    add_char(CH_PERCENT);
    add_char(CH_BKSP);
    queue_item(REQ_EOL, 8'($urandom), 8'($urandom));
    // Lone backslash, then a lone percent, waiting at end of line.
    add_char(CH_BSLASH);
    queue_item(REQ_EOL, 8'($urandom), 8'($urandom));
    add_char(CH_PERCENT);
    queue_item(REQ_EOL, 8'($urandom), 8'($urandom));

    // Random part: one token limit per phase, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      set_token_limit(lim_plan[ph]);
      burst_mode = ($urandom_range(0, 2) == 0);
      if (ph == 2) long_line(1'($urandom_range(0, 1)));
      else random_line();
    end
    burst_mode = 1'b0;

    // Drain: everything transferred, every result seen, then some quiet time
    // to catch anything extra.
    while (n_accepted != n_queued || report_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatch_cnt == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
